### src/tcv_pkg.sv
// Shared types and constants for the trace context validator.
// No dependencies; imported by every module under src.
package tcv_pkg;

  localparam int MAX_STATE_BYTES = 512;
  localparam int MAX_MEMBERS     = 32;

  localparam logic [9:0] PARENT_LEN  = 10'd55;
  localparam logic [9:0] POS_MAX     = 10'd1023;
  localparam logic [5:0] TOTAL_MAX   = 6'd63;
  localparam logic [9:0] STATE_LIMIT = 10'(MAX_STATE_BYTES);
  localparam logic [5:0] MEMBER_LIMIT = 6'(MAX_MEMBERS);

  localparam logic [9:0] POS_DASH_A    = 10'd2;
  localparam logic [9:0] POS_DASH_B    = 10'd35;
  localparam logic [9:0] POS_DASH_C    = 10'd52;
  localparam logic [9:0] POS_TRACE_END = 10'd34;
  localparam logic [9:0] POS_PAR_START = 10'd36;
  localparam logic [9:0] POS_PAR_END   = 10'd51;

  localparam logic [7:0] CHR_ZERO   = 8'h30;
  localparam logic [7:0] CHR_NINE   = 8'h39;
  localparam logic [7:0] CHR_LOW_A  = 8'h61;
  localparam logic [7:0] CHR_LOW_F  = 8'h66;
  localparam logic [7:0] CHR_DASH   = 8'h2D;
  localparam logic [7:0] CHR_SPACE  = 8'h20;
  localparam logic [7:0] CHR_TILDE  = 8'h7E;
  localparam logic [7:0] CHR_COMMA  = 8'h2C;
  localparam logic [7:0] CHR_EQUALS = 8'h3D;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       carries_byte;
    logic       which_part;
    logic       part_end;
    logic       state_follows;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic       ok;
  } result_t;

  typedef struct packed {
    logic [9:0] char_position;
    logic       parent_format_ok;
    logic       trace_id_nonzero;
    logic       parent_id_nonzero;
    logic       state_rules_ok;
    logic       member_is_empty;
    logic       member_starts_space;
    logic       previous_was_space;
    logic       member_has_equals;
    logic [5:0] member_total;
    logic       awaiting_state;
  } ctx_t;

  localparam ctx_t CTX_RESET = '{
    char_position:       10'd0,
    parent_format_ok:    1'b1,
    trace_id_nonzero:    1'b0,
    parent_id_nonzero:   1'b0,
    state_rules_ok:      1'b1,
    member_is_empty:     1'b1,
    member_starts_space: 1'b0,
    previous_was_space:  1'b0,
    member_has_equals:   1'b0,
    member_total:        6'd1,
    awaiting_state:      1'b0
  };

  function automatic logic is_low_hex(input logic [7:0] b);
    return ((b >= CHR_ZERO) && (b <= CHR_NINE)) || ((b >= CHR_LOW_A) && (b <= CHR_LOW_F));
  endfunction

endpackage

### src/trace_context_validator.sv
// Trace context validator top: input register, rule core, result register; uses tcv_pkg.
// A closing word passes the input register and the rule core; its verdict is registered in the result register.
// Throughput: one word per cycle; the input stalls only while the result
// register is full and its own stall is high.
// Reset (rst, synchronous): clears the pipe and returns the context to idle.
module trace_context_validator (
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  output logic       text_stall,
  input  logic [7:0] text_byte,
  input  logic       carries_byte,
  input  logic       which_part,
  input  logic       part_end,
  input  logic       state_follows,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       context_valid
);
  import tcv_pkg::*;

  logic    hold;
  logic    item_valid;
  item_t   item_in;
  item_t   item;
  result_t res;

  assign hold       = result_valid && result_stall;
  assign text_stall = hold;

  assign item_in = '{
    text_byte:     text_byte,
    carries_byte:  carries_byte,
    which_part:    which_part,
    part_end:      part_end,
    state_follows: state_follows
  };

  tcv_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .hold       (hold),
    .text_valid (text_valid),
    .item_in    (item_in),
    .item_valid (item_valid),
    .item       (item)
  );

  tcv_core u_core (
    .clk        (clk),
    .rst        (rst),
    .enable     (!hold),
    .item_valid (item_valid),
    .item       (item),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!hold) begin
      result_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      context_valid <= res.ok;
    end
  end

endmodule

### src/tcv_in_reg.sv
// Input register stage: captures one word per cycle unless the pipe is held.
// Depends on tcv_pkg.
module tcv_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           hold,
  input  logic           text_valid,
  input  tcv_pkg::item_t item_in,
  output logic           item_valid,
  output tcv_pkg::item_t item
);
  import tcv_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!hold) begin
      item_valid <= text_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      item <= item_in;
    end
  end

endmodule

### src/tcv_core.sv
// Context state and rule checks for traceparent and tracestate bytes.
// Depends on tcv_pkg.
module tcv_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             enable,
  input  logic             item_valid,
  input  tcv_pkg::item_t   item,
  output tcv_pkg::result_t res
);
  import tcv_pkg::*;

  ctx_t st;
  ctx_t st_next;

  always_comb begin
    logic [7:0] b;
    logic [9:0] p;
    logic       ok;
    b       = item.text_byte;
    p       = '0;
    ok      = 1'b1;
    st_next = st;
    res     = '0;
    if (enable && item_valid && (item.carries_byte || item.part_end)) begin
      if (!item.which_part) begin
        if (st.awaiting_state) begin
          st_next = CTX_RESET;
        end
        if (item.carries_byte) begin
          p = st_next.char_position;
          if (p <= 10'd1) begin
            ok = (b == CHR_ZERO);
          end else if ((p == POS_DASH_A) || (p == POS_DASH_B) || (p == POS_DASH_C)) begin
            ok = (b == CHR_DASH);
          end else if (p < PARENT_LEN) begin
            ok = is_low_hex(b);
            if (ok && (b != CHR_ZERO)) begin
              if (p <= POS_TRACE_END) begin
                st_next.trace_id_nonzero = 1'b1;
              end else if ((p >= POS_PAR_START) && (p <= POS_PAR_END)) begin
                st_next.parent_id_nonzero = 1'b1;
              end
            end
          end else begin
            ok = 1'b0;
          end
          if (!ok) begin
            st_next.parent_format_ok = 1'b0;
          end
          if (p < POS_MAX) begin
            st_next.char_position = p + 10'd1;
          end
        end
        if (item.part_end) begin
          if (st_next.char_position != PARENT_LEN) begin
            st_next.parent_format_ok = 1'b0;
          end
          if (item.state_follows) begin
            st_next.awaiting_state = 1'b1;
            st_next.char_position  = '0;
          end else begin
            res.valid = 1'b1;
            res.ok    = st_next.parent_format_ok && st_next.trace_id_nonzero &&
                        st_next.parent_id_nonzero;
            st_next   = CTX_RESET;
          end
        end
      end else if (st.awaiting_state) begin
        if (item.carries_byte) begin
          if (st.char_position >= STATE_LIMIT) begin
            st_next.state_rules_ok = 1'b0;
          end
          if (st.char_position < POS_MAX) begin
            st_next.char_position = st.char_position + 10'd1;
          end
          if ((b < CHR_SPACE) || (b > CHR_TILDE)) begin
            st_next.state_rules_ok = 1'b0;
          end
          if (b == CHR_COMMA) begin
            if (st.member_is_empty || st.member_starts_space || st.previous_was_space ||
                !st.member_has_equals) begin
              st_next.state_rules_ok = 1'b0;
            end
            st_next.member_is_empty     = 1'b1;
            st_next.member_starts_space = 1'b0;
            st_next.previous_was_space  = 1'b0;
            st_next.member_has_equals   = 1'b0;
            if (st.member_total < TOTAL_MAX) begin
              st_next.member_total = st.member_total + 6'd1;
            end
          end else begin
            if (st.member_is_empty && (b == CHR_SPACE)) begin
              st_next.member_starts_space = 1'b1;
            end
            st_next.member_is_empty    = 1'b0;
            st_next.previous_was_space = (b == CHR_SPACE);
            if (b == CHR_EQUALS) begin
              st_next.member_has_equals = 1'b1;
            end
          end
        end
        if (item.part_end) begin
          // closing member of the list
          if (st_next.member_is_empty || st_next.member_starts_space ||
              st_next.previous_was_space || !st_next.member_has_equals) begin
            st_next.state_rules_ok = 1'b0;
          end
          if (st_next.member_total > MEMBER_LIMIT) begin
            st_next.state_rules_ok = 1'b0;
          end
          res.valid = 1'b1;
          res.ok    = st_next.parent_format_ok && st_next.trace_id_nonzero &&
                      st_next.parent_id_nonzero && st_next.state_rules_ok;
          st_next   = CTX_RESET;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= CTX_RESET;
    end else begin
      st <= st_next;
    end
  end

  a_total_nonzero: assert property (@(posedge clk) disable iff (rst)
    st.member_total != 6'd0)
    else $error("member count reached zero");

  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    res.valid |=> (st == CTX_RESET))
    else $error("context not cleared after result");

  a_idle_members: assert property (@(posedge clk) disable iff (rst)
    !st.awaiting_state |-> (st.member_total == 6'd1) && st.member_is_empty &&
                           st.state_rules_ok)
    else $error("tracestate state touched outside a tracestate");

  a_no_result_idle: assert property (@(posedge clk) disable iff (rst)
    !(enable && item_valid) |-> !res.valid)
    else $error("result without a word");

endmodule
